// ===== hdl/sbfd_pkg.sv =====
`timescale 1ns / 1ps

package sbfd_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;
	localparam int CH_BITS     = 11;
	localparam int FLAG_POS    = 23;
	localparam int MUL_W       = 17;
	localparam int PROD_W      = CH_BITS + MUL_W;
	localparam int ROUND_VAL   = 32768;
	localparam int FRAC_BITS   = 16;

	localparam logic [7:0]  HDR_BYTE    = 8'h0F;
	localparam logic [11:0] SW_LOW      = 12'd998;
	localparam logic [11:0] SW_HIGH     = 12'd1998;
	localparam logic [4:0]  SW_CH_FIRST = 5'd16;
	localparam logic [4:0]  SW_CH_LAST  = 5'd17;

	localparam logic [1:0] CFG_GAP_TICKS    = 2'd0;
	localparam logic [1:0] CFG_MAX_CHANNELS = 2'd1;
	localparam logic [1:0] CFG_SCALE_MUL    = 2'd2;
	localparam logic [1:0] CFG_SCALE_OFFSET = 2'd3;

	typedef struct packed {
		logic tick;
		logic byte_in;
		logic hdr_drop;
		logic start;
		logic mul;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic byte_last;
		logic hdr_ok;
		logic cnt_zero;
		logic last;
		logic more_prop;
	} dp_stat_t;

endpackage

// ===== hdl/sbfd_if.sv =====
`timescale 1ns / 1ps

interface sbfd_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sbfd_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  channel_index;
	logic [11:0] channel_value;
	logic        failsafe;
	logic        frame_lost;
	logic [15:0] drop_count;
	logic        last;
	modport source (output valid, output channel_index, output channel_value,
		output failsafe, output frame_lost, output drop_count, output last, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input failsafe, input frame_lost, input drop_count, input last, output ready);
endinterface

interface sbfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sbfd_dp.sv =====
`timescale 1ns / 1ps

module sbfd_dp #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbfd_pkg::dp_cmd_t  cmd,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output sbfd_pkg::dp_stat_t stat,
	output logic [4:0]         channel_index,
	output logic [11:0]        channel_value,
	output logic               failsafe,
	output logic               frame_lost,
	output logic [15:0]        drop_count,
	output logic               last
);

	localparam logic [4:0] NUM_CH = 5'(NUM_CHANNELS);

	logic [sbfd_pkg::FRAME_BITS-1:0] frame_q;
	logic [4:0]                      byte_cnt_q;
	logic [15:0]                     idle_q;
	logic [15:0]                     drops_q;
	logic [15:0]                     gap_q;
	logic [4:0]                      maxch_q;
	logic [16:0]                     mul_q;
	logic [11:0]                     off_q;
	logic [3:0]                      flags_q;
	logic [4:0]                      ch_q;
	logic [sbfd_pkg::PROD_W-1:0]     prod_q;

	logic [15:0]                     idle_inc;
	logic [4:0]                      cnt;
	logic [5:0]                      ch_next;
	logic [sbfd_pkg::PROD_W:0]       rnd;
	logic [13:0]                     total;
	logic [11:0]                     scaled_val;
	logic [11:0]                     sw_val;

	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign cnt      = (maxch_q > NUM_CH) ? NUM_CH : maxch_q;
	assign ch_next  = {1'b0, ch_q} + 6'd1;

	assign rnd        = {1'b0, prod_q} + (sbfd_pkg::PROD_W + 1)'(sbfd_pkg::ROUND_VAL);
	assign total      = {1'b0, rnd[sbfd_pkg::PROD_W:sbfd_pkg::FRAC_BITS]} + {2'b00, off_q};
	assign scaled_val = (total > 14'd4095) ? 12'hFFF : total[11:0];
	assign sw_val     = flags_q[{1'b0, ch_q[0]}] ? sbfd_pkg::SW_HIGH : sbfd_pkg::SW_LOW;

	assign stat.byte_last = (byte_cnt_q == 5'(sbfd_pkg::FRAME_BYTES - 1));
	assign stat.hdr_ok    = (frame_q[7:0] == sbfd_pkg::HDR_BYTE);
	assign stat.cnt_zero  = (cnt == 5'd0);
	assign stat.more_prop = (ch_next < {1'b0, cnt});
	assign stat.last      = (ch_q == sbfd_pkg::SW_CH_LAST) ||
		((ch_next == {1'b0, cnt}) && (cnt < sbfd_pkg::SW_CH_FIRST));

	assign channel_index = ch_q;
	assign channel_value = (ch_q >= sbfd_pkg::SW_CH_FIRST) ? sw_val : scaled_val;
	assign failsafe      = flags_q[3];
	assign frame_lost    = flags_q[3] | flags_q[2];
	assign drop_count    = drops_q;
	assign last          = stat.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			idle_q     <= '0;
			drops_q    <= '0;
			gap_q      <= 16'd3000;
			maxch_q    <= 5'd16;
			mul_q      <= 17'd40960;
			off_q      <= 12'd875;
			ch_q       <= '0;
			flags_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sbfd_pkg::CFG_GAP_TICKS:    gap_q   <= cfg_data[15:0];
					sbfd_pkg::CFG_MAX_CHANNELS: maxch_q <= cfg_data[4:0];
					sbfd_pkg::CFG_SCALE_MUL:    mul_q   <= cfg_data;
					sbfd_pkg::CFG_SCALE_OFFSET: off_q   <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (cmd.tick) begin
				idle_q <= idle_inc;
				if ((idle_inc > gap_q) && (byte_cnt_q != 5'd0)) begin
					drops_q    <= drops_q + 16'd1;
					byte_cnt_q <= '0;
				end
			end
			if (cmd.byte_in) begin
				idle_q     <= '0;
				byte_cnt_q <= stat.byte_last ? 5'd0 : byte_cnt_q + 5'd1;
			end
			if (cmd.hdr_drop) begin
				drops_q <= drops_q + 16'd1;
			end
			if (cmd.start) begin
				flags_q <= frame_q[sbfd_pkg::FLAG_POS*8 +: 4];
				ch_q    <= '0;
			end
			if (cmd.advance) begin
				ch_q <= ch_next[4:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_in) begin
			frame_q <= {rx_byte, frame_q[sbfd_pkg::FRAME_BITS-1:8]};
		end else if (cmd.mul) begin
			frame_q <= frame_q >> sbfd_pkg::CH_BITS;
		end
		if (cmd.mul) begin
			prod_q <= {{sbfd_pkg::MUL_W{1'b0}}, frame_q[8 +: sbfd_pkg::CH_BITS]} *
				{{sbfd_pkg::CH_BITS{1'b0}}, mul_q};
		end
	end

endmodule

// ===== hdl/sbfd_ctrl.sv =====
`timescale 1ns / 1ps

module sbfd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sbfd_pkg::dp_stat_t stat,
	output sbfd_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_MUL   = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   in_acc, out_acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid & in_ready;
	assign out_acc   = out_valid & out_ready;

	always_comb begin
		cmd          = '0;
		cmd.tick     = in_acc & in_opcode;
		cmd.byte_in  = in_acc & ~in_opcode;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.byte_in && stat.byte_last) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.hdr_ok) begin
					cmd.hdr_drop = 1'b1;
					state_d      = S_IDLE;
				end else if (stat.cnt_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_acc) begin
					if (stat.last) begin
						state_d = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = stat.more_prop ? S_MUL : S_OUT;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/sbus_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// S.BUS frame decoder. Each input transaction is one received byte or one time
// tick; in idle both are taken at one per cycle. After the 25th byte the block
// checks the header, then for each proportional channel uses the shared 11x17
// multiplier (S_MUL) and then presents the result (S_OUT), where it may be held
// by an output stall; the two switch channels are only presented, without the
// multiplier, and only when 16 proportional channels are decoded. Input is not
// taken until the final result of the frame has been transferred.
module sbus_frame_decoder_core #(
	parameter int NUM_CHANNELS = 16
) (
	input logic         clk,
	input logic         arst_n,
	sbfd_in_if.sink     rx_in,
	sbfd_out_if.source  res_out,
	sbfd_cfg_if.sink    cfg
);

	sbfd_pkg::dp_cmd_t  cmd;
	sbfd_pkg::dp_stat_t stat;

	assign cfg.ready = 1'b1;

	sbfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_in.valid),
		.in_opcode (rx_in.opcode),
		.in_ready  (rx_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sbfd_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rx_byte       (rx_in.rx_byte),
		.cfg_we        (cfg.valid & cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.stat          (stat),
		.channel_index (res_out.channel_index),
		.channel_value (res_out.channel_value),
		.failsafe      (res_out.failsafe),
		.frame_lost    (res_out.frame_lost),
		.drop_count    (res_out.drop_count),
		.last          (res_out.last)
	);

endmodule
